// ----- rtl/tsdsc_pkg.sv -----
// tsdsc_pkg: shared types, constants and gf(2^8) / aes helper functions
// for the transport stream descrambler; no dependencies
`timescale 1ns / 1ps

package tsdsc_pkg;

    localparam int PKT_LEN   = 188;
    localparam int BLK_BYTES = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_PROC,
        ST_KICK,
        ST_CRYPT,
        ST_DRAIN
    } top_state_t;

    typedef enum logic [1:0] {
        AES_IDLE,
        AES_EXP,
        AES_INIT,
        AES_ROUND
    } aes_state_t;

    typedef enum logic [1:0] {
        REG_EVEN_HIGH = 2'd0,
        REG_EVEN_LOW  = 2'd1,
        REG_ODD_HIGH  = 2'd2,
        REG_ODD_LOW   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } aes_stat_t;

    function automatic logic [7:0] gf_xt(input logic [7:0] a);
        gf_xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r = r ^ x;
            x = gf_xt(x);
        end
        gf_mul = r;
    endfunction

    // multiplicative inverse table, built at elaboration (a^254)
    function automatic logic [2047:0] gen_inv();
        logic [2047:0] tbl;
        logic [7:0]    r;
        logic [7:0]    p;
        for (int a = 0; a < 256; a++)
        begin
            r = 8'h01;
            p = 8'(a);
            for (int e = 0; e < 8; e++)
            begin
                if (((254 >> e) & 1) == 1)
                    r = gf_mul(r, p);
                p = gf_mul(p, p);
            end
            tbl[a*8 +: 8] = (a == 0) ? 8'h00 : r;
        end
        gen_inv = tbl;
    endfunction

    localparam logic [2047:0] INV_TBL = gen_inv();

    function automatic logic [7:0] rotl(input logic [7:0] v, input int s);
        rotl = 8'((v << s) | (v >> (8 - s)));
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] v;
        v = INV_TBL[{x, 3'b000} +: 8];
        sbox = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] y);
        logic [7:0] v;
        v = rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05;
        isbox = INV_TBL[{v, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        case (r)
            4'd1:    rcon = 8'h01;
            4'd2:    rcon = 8'h02;
            4'd3:    rcon = 8'h04;
            4'd4:    rcon = 8'h08;
            4'd5:    rcon = 8'h10;
            4'd6:    rcon = 8'h20;
            4'd7:    rcon = 8'h40;
            4'd8:    rcon = 8'h80;
            4'd9:    rcon = 8'h1b;
            4'd10:   rcon = 8'h36;
            default: rcon = 8'h00;
        endcase
    endfunction

    // key schedule word function: rotate, substitute, add round constant
    function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
        key_g = {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        w0 = k[127:96] ^ key_g(k[31:0], rc);
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        key_fwd = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] key_back(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        w0 = k[127:96] ^ key_g(w3, rc);
        key_back = {w0, w1, w2, w3};
    endfunction

    // one inverse round: inv shift rows, inv sub bytes, add key, inv mix columns when mix is set
    function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic mix);
        logic [7:0]   t [16];
        logic [127:0] u;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i + 4 * ((c + i) % 4)] = isbox(s[8 * (15 - (i + 4 * c)) +: 8]);
        for (int i = 0; i < 16; i++)
            u[8 * (15 - i) +: 8] = t[i] ^ k[8 * (15 - i) +: 8];
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = u[8 * (15 - 4 * c) +: 8];
                a1 = u[8 * (14 - 4 * c) +: 8];
                a2 = u[8 * (13 - 4 * c) +: 8];
                a3 = u[8 * (12 - 4 * c) +: 8];
                u[8 * (15 - 4 * c) +: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                         ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                u[8 * (14 - 4 * c) +: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                         ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                u[8 * (13 - 4 * c) +: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                         ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                u[8 * (12 - 4 * c) +: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                         ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
            end
        end
        inv_round = u;
    endfunction

endpackage

// ----- rtl/ts_packet_aes128_ecb_descrambler_core.sv -----
// ts_packet_aes128_ecb_descrambler_core: top level, byte sequencer and block buffer
// depends on tsdsc_pkg and tsdsc_aes_core
`timescale 1ns / 1ps
// flow: a clear byte passes the pending register, then the output register; a byte
//   that completes a block starts the aes unit, which runs key expansion, the initial
//   add, the rounds and a handoff before the block's 16 output bytes are sent
// input: a new byte is taken only once the last one is done, a whole block included;
//   a packet start with held bytes first sends each held byte out in the clear
// reset: rst_n asynchronous active low, clears control state and keys; no clearing pass

module ts_packet_aes128_ecb_descrambler_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] packet_byte
    input  logic [0:0]  s_tuser,     // [0] packet_start
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] out_byte
    output logic        m_tlast,     // run_last
    output logic [0:0]  m_tuser,     // [0] packet_end
    // key register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import tsdsc_pkg::*;

    localparam logic [7:0] LAST_POS = 8'(PKT_LEN - 1);

    top_state_t state_reg;
    top_state_t state_next;

    // packet tracking
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic       scr_reg;
    logic       scr_next;
    logic       ksel_reg;
    logic       ksel_next;
    logic [8:0] off_reg;
    logic [8:0] off_next;
    logic [4:0] fill_reg;
    logic [4:0] fill_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       end_reg;
    logic       end_next;

    // pending input item
    logic [7:0] pbyte_reg;
    logic [7:0] pbyte_next;
    logic       pstart_reg;
    logic       pstart_next;

    // output register
    logic       ov_reg;
    logic       ov_next;
    logic [7:0] od_reg;
    logic [7:0] od_next;
    logic       olast_reg;
    logic       olast_next;
    logic       oend_reg;
    logic       oend_next;

    // block buffer
    logic [7:0] buf_reg [BLK_BYTES];
    logic       buf_we;
    logic [127:0] blk_vec;

    // key registers
    logic [63:0] ek_hi_reg;
    logic [63:0] ek_lo_reg;
    logic [63:0] ok_hi_reg;
    logic [63:0] ok_lo_reg;

    // aes unit
    logic         aes_start;
    logic [127:0] aes_key;
    aes_stat_t    aes_stat;
    logic [127:0] aes_res;

    // per-byte decode
    logic [7:0] p;
    logic       at_end;
    logic [8:0] off_upd;
    logic [8:0] span;
    logic [8:0] limit;
    logic       in_block;
    logic       slot_free;
    logic [4:0] fill_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ek_hi_reg <= '0;
            ek_lo_reg <= '0;
            ok_hi_reg <= '0;
            ok_lo_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_EVEN_HIGH: ek_hi_reg <= cfg_data;
                REG_EVEN_LOW:  ek_lo_reg <= cfg_data;
                REG_ODD_HIGH:  ok_hi_reg <= cfg_data;
                REG_ODD_LOW:   ok_lo_reg <= cfg_data;
                default:       ek_hi_reg <= ek_hi_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            scr_reg   <= 1'b0;
            ksel_reg  <= 1'b0;
            off_reg   <= 9'd4;
            fill_reg  <= '0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            scr_reg   <= scr_next;
            ksel_reg  <= ksel_next;
            off_reg   <= off_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbyte_reg  <= pbyte_next;
        pstart_reg <= pstart_next;
        end_reg    <= end_next;
        od_reg     <= od_next;
        olast_reg  <= olast_next;
        oend_reg   <= oend_next;
        if (buf_we)
            buf_reg[fill_reg[3:0]] <= pbyte_reg;
    end

    // byte 0 of the buffer goes to the top of the cipher block
    always_comb
    begin
        for (int i = 0; i < BLK_BYTES; i++)
            blk_vec[8 * (15 - i) +: 8] = buf_reg[i];
    end

    assign aes_key = ksel_reg ? {ok_hi_reg, ok_lo_reg} : {ek_hi_reg, ek_lo_reg};

    tsdsc_aes_core u_aes
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (aes_start),
        .key_in (aes_key),
        .blk_in (blk_vec),
        .stat   (aes_stat),
        .result (aes_res)
    );

    // position of the pending byte and the scrambled payload window
    always_comb
    begin
        if (pstart_reg || pos_reg > LAST_POS)
            p = 8'd0;
        else
            p = pos_reg;
        at_end = (p == LAST_POS);
        // adaptation field: offset taken at 9 bits, no wrap
        if (p == 8'd4 && scr_reg && off_reg == 9'd5)
            off_upd = 9'd5 + {1'b0, pbyte_reg};
        else
            off_upd = off_reg;
        span  = 9'(PKT_LEN) - off_upd;
        if (off_upd <= 9'(PKT_LEN))
            limit = off_upd + {span[8:4], 4'b0000};
        else
            limit = off_upd;
        in_block = (p != 8'd3) && scr_reg && ({1'b0, p} >= off_upd) && ({1'b0, p} < limit);
    end

    assign slot_free = !ov_reg || m_tready;
    assign fill_inc  = fill_reg + 5'd1;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        scr_next    = scr_reg;
        ksel_next   = ksel_reg;
        off_next    = off_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        end_next    = end_reg;
        pbyte_next  = pbyte_reg;
        pstart_next = pstart_reg;
        ov_next     = ov_reg && !m_tready;
        od_next     = od_reg;
        olast_next  = olast_reg;
        oend_next   = oend_reg;
        buf_we      = 1'b0;
        aes_start   = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    pbyte_next  = s_tdata;
                    pstart_next = s_tuser[0];
                    idx_next    = '0;
                    // packet start inside a block: held bytes leave in the clear first
                    if (s_tuser[0] && fill_reg != 5'd0)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_PROC;
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = buf_reg[idx_reg];
                    olast_next = 1'b0;
                    oend_next  = 1'b0;
                    idx_next   = idx_reg + 4'd1;
                    if ({1'b0, idx_reg} == fill_reg - 5'd1)
                    begin
                        fill_next  = '0;
                        state_next = ST_PROC;
                    end
                end
            end
            ST_PROC:
            begin
                if (in_block || slot_free)
                begin
                    pos_next = at_end ? 8'd0 : p + 8'd1;
                    if (p == 8'd3)
                    begin
                        scr_next  = pbyte_reg[7];
                        ksel_next = pbyte_reg[6];
                        off_next  = (pbyte_reg[7] && pbyte_reg[5]) ? 9'd5 : 9'd4;
                    end
                    else
                    begin
                        off_next = off_upd;
                    end
                    if (in_block)
                    begin
                        buf_we    = 1'b1;
                        fill_next = fill_inc;
                        end_next  = at_end;
                        if (fill_inc == 5'(BLK_BYTES))
                            state_next = ST_KICK;
                        else
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        od_next    = (p == 8'd3 && pbyte_reg[7]) ? (pbyte_reg & 8'h3f)
                                                                : pbyte_reg;
                        olast_next = 1'b1;
                        oend_next  = at_end;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_KICK:
            begin
                aes_start  = 1'b1;
                state_next = ST_CRYPT;
            end
            ST_CRYPT:
            begin
                if (aes_stat.done)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = aes_res[{~idx_reg, 3'b000} +: 8];
                    olast_next = (idx_reg == 4'd15);
                    oend_next  = (idx_reg == 4'd15) && end_reg;
                    idx_next   = idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid   = ov_reg;
    assign m_tdata    = od_reg;
    assign m_tlast    = olast_reg;
    assign m_tuser[0] = oend_reg;

    // buffer never holds more than one block
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 5'd16)
        else $error("block fill overflow");
    // the aes unit is running whenever we wait on it without a result yet
    a_crypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRYPT && !aes_stat.done) |-> aes_stat.busy)
        else $error("waiting on idle aes unit");
    // a block kick always follows a full buffer
    a_kick_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_KICK |-> fill_reg == 5'd16)
        else $error("aes started on partial block");
    // drain only starts once the aes result is final
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DRAIN) |-> aes_stat.done)
        else $error("drain before aes done");

endmodule

// ----- rtl/tsdsc_aes_core.sv -----
// tsdsc_aes_core: iterative aes-128 inverse cipher, one round per cycle
// depends on tsdsc_pkg
`timescale 1ns / 1ps

module tsdsc_aes_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [127:0]         key_in,
    input  logic [127:0]         blk_in,
    output tsdsc_pkg::aes_stat_t stat,
    output logic [127:0]         result
);
    import tsdsc_pkg::*;

    aes_state_t   st_reg;
    aes_state_t   st_next;
    logic [3:0]   cnt_reg;
    logic [3:0]   cnt_next;
    logic         done_reg;
    logic         done_next;
    logic [127:0] key_reg;
    logic [127:0] key_next;
    logic [127:0] s_reg;
    logic [127:0] s_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= AES_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        s_reg   <= s_next;
    end

    // expand forward to the last round key, then walk it back per round
    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        key_next  = key_reg;
        s_next    = s_reg;
        case (st_reg)
            AES_IDLE:
            begin
                if (start)
                begin
                    key_next  = key_in;
                    s_next    = blk_in;
                    cnt_next  = 4'd1;
                    done_next = 1'b0;
                    st_next   = AES_EXP;
                end
            end
            AES_EXP:
            begin
                key_next = key_fwd(key_reg, rcon(cnt_reg));
                if (cnt_reg == 4'd10)
                    st_next = AES_INIT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            AES_INIT:
            begin
                s_next   = s_reg ^ key_reg;
                key_next = key_back(key_reg, rcon(4'd10));
                cnt_next = 4'd9;
                st_next  = AES_ROUND;
            end
            AES_ROUND:
            begin
                s_next = inv_round(s_reg, key_reg, cnt_reg != 4'd0);
                if (cnt_reg != 4'd0)
                begin
                    key_next = key_back(key_reg, rcon(cnt_reg));
                    cnt_next = cnt_reg - 4'd1;
                end
                else
                begin
                    done_next = 1'b1;
                    st_next   = AES_IDLE;
                end
            end
            default:
            begin
                st_next = AES_IDLE;
            end
        endcase
    end

    assign stat.busy = (st_reg != AES_IDLE);
    assign stat.done = done_reg;
    assign result    = s_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 4'd10)
        else $error("round counter out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> st_reg == AES_IDLE)
        else $error("done while busy");
    a_init_after_exp: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == AES_INIT |-> $past(st_reg) == AES_EXP)
        else $error("init not preceded by key expansion");

endmodule
